/* design/tdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg
// Types, codes and constants shared by the time display digit formatter.
// ----------------------------------------------------------------------------
package tdf_pkg;

    // Port widths
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    // Internal value widths
    localparam int PAIR_W  = 7;   // two-digit value below 128
    localparam int Y_W     = 31;  // pre-shifted dividend
    localparam int Q_W     = 29;  // first quotient
    localparam int HI_W    = 23;  // second quotient
    localparam int H3_W    = 17;  // hundreds of the second quotient
    localparam int RCP1_W  = 30;
    localparam int RCP2_W  = 27;
    localparam int RCP3_W  = 26;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWELVE_HOUR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLON_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_FORMAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_AUTO_TIMER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_COLON       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_DECIMAL     = 3'd6;

    // Display modes
    localparam logic [2:0] MODE_CLOCK     = 3'd0;
    localparam logic [2:0] MODE_CLOCK_SEC = 3'd1;
    localparam logic [2:0] MODE_TIMER     = 3'd2;
    localparam logic [2:0] MODE_STOPWATCH = 3'd3;
    localparam logic [2:0] MODE_DEMO      = 3'd4;

    // Clock colon modes
    localparam logic [1:0] COLON_BLINK = 2'd0;
    localparam logic [1:0] COLON_ON    = 2'd1;
    localparam logic [1:0] COLON_OFF   = 2'd2;

    // Timer formats
    localparam logic [1:0] TFMT_AUTO = 2'd0;
    localparam logic [1:0] TFMT_HHMM = 2'd1;
    localparam logic [1:0] TFMT_MMSS = 2'd2;
    localparam logic [1:0] TFMT_SSCS = 2'd3;

    // Result layouts
    localparam logic [2:0] LAYOUT_CLOCK = 3'd0;
    localparam logic [2:0] LAYOUT_HHMM  = 3'd1;
    localparam logic [2:0] LAYOUT_MMSS  = 3'd2;
    localparam logic [2:0] LAYOUT_SSCS  = 3'd3;
    localparam logic [2:0] LAYOUT_DEMO  = 3'd4;

    // Range thresholds and round-up offsets in ms
    localparam logic [31:0] HOUR_MS       = 32'd3600000;
    localparam logic [31:0] MINUTE_MS     = 32'd60000;
    localparam logic [32:0] ROUND_UP_MIN  = 33'd59999;
    localparam logic [32:0] ROUND_UP_SEC  = 33'd999;

    // Reciprocals, floor(2^32 / divisor)
    localparam logic [RCP1_W-1:0] RCP_5    = 30'd858993459;
    localparam logic [RCP1_W-1:0] RCP_125  = 30'd34359738;
    localparam logic [RCP1_W-1:0] RCP_1875 = 30'd2290649;
    localparam logic [RCP2_W-1:0] RCP_60   = 27'd71582788;
    localparam logic [RCP2_W-1:0] RCP_100  = 27'd42949672;
    localparam logic [RCP3_W-1:0] RCP_H100 = 26'd42949672;

    typedef enum logic [1:0] {
        DIV_5,
        DIV_125,
        DIV_1875
    } msel_t;

    typedef enum logic {
        KDIV_60,
        KDIV_100
    } ksel_t;

    typedef struct packed {
        logic [2:0] display_mode;
        logic       twelve_hour;
        logic [1:0] colon_mode;
        logic [1:0] timer_format;
        logic       force_auto_timer;
        logic       show_colon;
        logic       show_decimal;
    } cfg_t;

    typedef struct packed {
        logic       blank;
        logic       colon;
        logic       dec;
        logic [2:0] layout;
        logic       direct;   // digits come from the pair values, not arithmetic
        msel_t      msel;
        ksel_t      ksel;
    } flags_t;

    typedef struct packed {
        flags_t              flags;
        logic [PAIR_W-1:0]   pair_hi;
        logic [PAIR_W-1:0]   pair_lo;
    } tag_t;

    typedef struct packed {
        tag_t           tag;
        logic [Y_W-1:0] y;
    } front_t;

    typedef struct packed {
        tag_t           tag;
        logic [Q_W-1:0] q;
    } quot_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    typedef struct packed {
        logic [3:0] digit_0;
        logic [3:0] digit_1;
        logic [3:0] digit_2;
        logic [3:0] digit_3;
        logic       blank_leading;
        logic       colon_on;
        logic       decimal_on;
        logic [2:0] layout;
    } result_t;

    // Tens and ones of a value below 100 (v * 205 >> 11 equals v / 10 here)
    function automatic digits_t split_pair(input logic [PAIR_W-1:0] v);
        logic [14:0] prod;
        logic [7:0]  tens_x10;
        digits_t     d;
        prod       = v * 8'd205;
        d.tens     = prod[14:11];
        tens_x10   = d.tens * 4'd10;
        d.ones     = 4'(v[3:0] - tens_x10[3:0]);
        return d;
    endfunction

endpackage

/* design/time_display_digit_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_display_digit_formatter
// Formats time of day, countdown or stopwatch time as four display digits
// with blank, colon, decimal point and layout flags.
//
//   Channel   Direction  Handshake              Contents
//   s_axis    in         tvalid/tready          hour, minute, second, timer ms,
//                                               stopwatch ms
//   m_axis    out        tvalid/tready          digits, flags, layout
//   cfg       in         cfg_we (no wait)       one register per write
//
// One item is taken per cycle unless the output stalls. The depth is set by
// the three reciprocal divide steps (by 5/125/1875, by 60/100, by 100), each
// a multiply stage followed by a correction stage, plus decode and output.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage has its own ready, so bubbles close up under an output stall
// and an item is never dropped or repeated.
// ----------------------------------------------------------------------------
module time_display_digit_formatter (
    input  logic                              clk,
    input  logic                              rst_n,
    // hour[4:0], minute[10:5], second[16:11], timer_remaining_ms[48:17],
    // stopwatch_elapsed_ms[80:49], zero fill[87:81]
    input  logic [tdf_pkg::S_DATA_W-1:0]      s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // digit_0[3:0], digit_1[7:4], digit_2[11:8], digit_3[15:12],
    // blank_leading[16], colon_on[17], decimal_on[18], layout[21:19],
    // zero fill[23:22]
    output logic [tdf_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tdf_pkg::*;

    cfg_t    cfg_reg;
    logic    fr_valid;
    logic    fr_ready;
    front_t  fr_data;
    logic    qu_valid;
    logic    qu_ready;
    quot_t   qu_data;
    logic    sp_valid;
    logic    sp_ready;
    tag_t    sp_data;
    result_t res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_mode     <= MODE_CLOCK;
            cfg_reg.twelve_hour      <= 1'b0;
            cfg_reg.colon_mode       <= COLON_BLINK;
            cfg_reg.timer_format     <= TFMT_AUTO;
            cfg_reg.force_auto_timer <= 1'b0;
            cfg_reg.show_colon       <= 1'b1;
            cfg_reg.show_decimal     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISPLAY_MODE:     cfg_reg.display_mode     <= cfg_data[2:0];
                REG_TWELVE_HOUR:      cfg_reg.twelve_hour      <= cfg_data[0];
                REG_COLON_MODE:       cfg_reg.colon_mode       <= cfg_data[1:0];
                REG_TIMER_FORMAT:     cfg_reg.timer_format     <= cfg_data[1:0];
                REG_FORCE_AUTO_TIMER: cfg_reg.force_auto_timer <= cfg_data[0];
                REG_SHOW_COLON:       cfg_reg.show_colon       <= cfg_data[0];
                REG_SHOW_DECIMAL:     cfg_reg.show_decimal     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Decode
    tdf_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .in_valid             (s_axis_tvalid),
        .in_ready             (s_axis_tready),
        .hour                 (s_axis_tdata[4:0]),
        .minute               (s_axis_tdata[10:5]),
        .second               (s_axis_tdata[16:11]),
        .timer_remaining_ms   (s_axis_tdata[48:17]),
        .stopwatch_elapsed_ms (s_axis_tdata[80:49]),
        .out_valid            (fr_valid),
        .out_ready            (fr_ready),
        .out_data             (fr_data)
    );

    // Divide by the unit size
    tdf_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (qu_valid),
        .out_ready (qu_ready),
        .out_data  (qu_data)
    );

    // Split into two-digit pairs
    tdf_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qu_valid),
        .in_ready  (qu_ready),
        .in_data   (qu_data),
        .out_valid (sp_valid),
        .out_ready (sp_ready),
        .out_data  (sp_data)
    );

    // Digits and output register
    tdf_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sp_valid),
        .in_ready  (sp_ready),
        .in_data   (sp_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // Pack the result item
    assign m_axis_tdata = {2'b00, res.layout, res.decimal_on, res.colon_on,
                           res.blank_leading, res.digit_3, res.digit_2,
                           res.digit_1, res.digit_0};

endmodule

/* design/tdf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_front
// Decode stage: picks layout and flags, rounds up the timer count and pre-shifts the ms count.
// ----------------------------------------------------------------------------
module tdf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdf_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [4:0]           hour,
    input  logic [5:0]           minute,
    input  logic [5:0]           second,
    input  logic [31:0]          timer_remaining_ms,
    input  logic [31:0]          stopwatch_elapsed_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdf_pkg::front_t      out_data
);
    import tdf_pkg::*;

    logic        valid_reg;
    front_t      data_reg;
    front_t      data_next;
    logic        en;
    logic [4:0]  hour12;
    logic [1:0]  tfmt_sel;
    logic [1:0]  tfmt;
    logic [1:0]  tfmt_auto;
    logic [1:0]  sfmt;
    logic [32:0] tms_rnd_min;
    logic [32:0] tms_rnd_sec;

    // Advance when empty or when the next stage takes the item
    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Hour on a 12-hour dial, zero shown as twelve
    always_comb
    begin
        if (hour >= 5'd24)
        begin
            hour12 = hour - 5'd24;
        end
        else if (hour >= 5'd12)
        begin
            hour12 = hour - 5'd12;
        end
        else
        begin
            hour12 = hour;
        end
        if (hour12 == 5'd0)
        begin
            hour12 = 5'd12;
        end
    end

    // Timer and stopwatch layout choice
    assign tms_rnd_min = {1'b0, timer_remaining_ms} + ROUND_UP_MIN;
    assign tms_rnd_sec = {1'b0, timer_remaining_ms} + ROUND_UP_SEC;

    always_comb
    begin
        if (timer_remaining_ms >= HOUR_MS)
        begin
            tfmt_auto = TFMT_HHMM;
        end
        else if (timer_remaining_ms >= MINUTE_MS)
        begin
            tfmt_auto = TFMT_MMSS;
        end
        else
        begin
            tfmt_auto = TFMT_SSCS;
        end
        tfmt_sel = cfg.force_auto_timer ? TFMT_AUTO : cfg.timer_format;
        tfmt     = (tfmt_sel == TFMT_AUTO) ? tfmt_auto : tfmt_sel;

        if (stopwatch_elapsed_ms < MINUTE_MS)
        begin
            sfmt = TFMT_SSCS;
        end
        else if (stopwatch_elapsed_ms < HOUR_MS)
        begin
            sfmt = TFMT_MMSS;
        end
        else
        begin
            sfmt = TFMT_HHMM;
        end
    end

    // Build the item for the divider chain
    always_comb
    begin
        data_next                  = '0;
        data_next.tag.flags.colon  = 1'b1;
        data_next.tag.flags.direct = 1'b1;
        data_next.tag.flags.layout = LAYOUT_CLOCK;
        data_next.tag.flags.msel   = DIV_5;
        data_next.tag.flags.ksel   = KDIV_100;

        case (cfg.display_mode)
            MODE_CLOCK, MODE_CLOCK_SEC:
            begin
                data_next.tag.pair_hi = cfg.twelve_hour ? {2'b00, hour12} : {2'b00, hour};
                data_next.tag.pair_lo = {1'b0, minute};
                data_next.tag.flags.blank = cfg.twelve_hour && (hour12 < 5'd10);
                case (cfg.colon_mode)
                    COLON_BLINK: data_next.tag.flags.colon = ~second[0];
                    COLON_OFF:   data_next.tag.flags.colon = 1'b0;
                    default:     data_next.tag.flags.colon = 1'b1;
                endcase
            end
            MODE_TIMER:
            begin
                data_next.tag.flags.direct = 1'b0;
                case (tfmt)
                    TFMT_HHMM:
                    begin
                        data_next.y                = {3'b000, tms_rnd_min[32:5]};
                        data_next.tag.flags.msel   = DIV_1875;
                        data_next.tag.flags.ksel   = KDIV_60;
                        data_next.tag.flags.layout = LAYOUT_HHMM;
                    end
                    TFMT_MMSS:
                    begin
                        data_next.y                = {1'b0, tms_rnd_sec[32:3]};
                        data_next.tag.flags.msel   = DIV_125;
                        data_next.tag.flags.ksel   = KDIV_60;
                        data_next.tag.flags.layout = LAYOUT_MMSS;
                    end
                    default:
                    begin
                        data_next.y                = timer_remaining_ms[31:1];
                        data_next.tag.flags.layout = LAYOUT_SSCS;
                        data_next.tag.flags.colon  = 1'b0;
                        data_next.tag.flags.dec    = 1'b1;
                    end
                endcase
            end
            MODE_STOPWATCH:
            begin
                data_next.tag.flags.direct = 1'b0;
                case (sfmt)
                    TFMT_HHMM:
                    begin
                        data_next.y                = {4'b0000, stopwatch_elapsed_ms[31:5]};
                        data_next.tag.flags.msel   = DIV_1875;
                        data_next.tag.flags.ksel   = KDIV_60;
                        data_next.tag.flags.layout = LAYOUT_HHMM;
                    end
                    TFMT_MMSS:
                    begin
                        data_next.y                = {2'b00, stopwatch_elapsed_ms[31:3]};
                        data_next.tag.flags.msel   = DIV_125;
                        data_next.tag.flags.ksel   = KDIV_60;
                        data_next.tag.flags.layout = LAYOUT_MMSS;
                    end
                    default:
                    begin
                        data_next.y                = stopwatch_elapsed_ms[31:1];
                        data_next.tag.flags.layout = LAYOUT_SSCS;
                        data_next.tag.flags.colon  = 1'b0;
                        data_next.tag.flags.dec    = 1'b1;
                    end
                endcase
            end
            MODE_DEMO:
            begin
                data_next.tag.pair_hi      = 7'd12;
                data_next.tag.pair_lo      = 7'd34;
                data_next.tag.flags.dec    = 1'b1;
                data_next.tag.flags.layout = LAYOUT_DEMO;
            end
            default:
            begin
                data_next.tag.flags.layout = LAYOUT_CLOCK;
            end
        endcase

        // Face overrides
        if (!cfg.show_colon)
        begin
            data_next.tag.flags.colon = 1'b0;
        end
        if (!cfg.show_decimal &&
            !(cfg.display_mode inside {MODE_TIMER, MODE_STOPWATCH, MODE_DEMO}))
        begin
            data_next.tag.flags.dec = 1'b0;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/tdf_quot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_quot
// Two stages: divide the pre-shifted count by 5, 125 or 1875 through a
// reciprocal product, then correct the estimate by one.
// ----------------------------------------------------------------------------
module tdf_quot (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tdf_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tdf_pkg::quot_t   out_data
);
    import tdf_pkg::*;

    logic                     a_valid_reg;
    front_t                   a_data_reg;
    logic [Q_W-1:0]           a_qest_reg;
    logic [Q_W-1:0]           a_qest_next;
    logic                     b_valid_reg;
    quot_t                    b_data_reg;
    quot_t                    b_data_next;
    logic                     en_a;
    logic                     en_b;
    logic [RCP1_W-1:0]        rcp;
    logic [Y_W+RCP1_W-1:0]    prod;
    logic [11:0]              mval;
    logic [23:0]              qm;
    logic [11:0]              rem;

    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Estimate the quotient from the reciprocal, at most one low
    always_comb
    begin
        case (in_data.tag.flags.msel)
            DIV_125:  rcp = RCP_125;
            DIV_1875: rcp = RCP_1875;
            default:  rcp = RCP_5;
        endcase
        prod        = in_data.y * rcp;
        a_qest_next = prod[Q_W+31:32];
    end

    // Check the remainder and step the estimate up when it reaches the divisor
    always_comb
    begin
        case (a_data_reg.tag.flags.msel)
            DIV_125:  mval = 12'd125;
            DIV_1875: mval = 12'd1875;
            default:  mval = 12'd5;
        endcase
        qm              = a_qest_reg[11:0] * mval;
        rem             = a_data_reg.y[11:0] - qm[11:0];
        b_data_next.tag = a_data_reg.tag;
        b_data_next.q   = (rem >= mval) ? a_qest_reg + 1'b1 : a_qest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_data_reg <= in_data;
            a_qest_reg <= a_qest_next;
        end
        if (en_b)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

/* design/tdf_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_split
// Four stages: split the quotient by 60 or 100 into a high and a low part,
// then reduce the high part modulo 100 and pick arithmetic or direct pairs.
// ----------------------------------------------------------------------------
module tdf_split (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tdf_pkg::quot_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tdf_pkg::tag_t    out_data
);
    import tdf_pkg::*;

    logic                   c_valid_reg;
    quot_t                  c_data_reg;
    logic [HI_W-1:0]        c_hiest_reg;
    logic [HI_W-1:0]        c_hiest_next;
    logic                   d_valid_reg;
    tag_t                   d_tag_reg;
    logic [HI_W-1:0]        d_hi_reg;
    logic [HI_W-1:0]        d_hi_next;
    logic [PAIR_W-1:0]      d_lo_reg;
    logic [PAIR_W-1:0]      d_lo_next;
    logic                   e_valid_reg;
    tag_t                   e_tag_reg;
    logic [HI_W-1:0]        e_hi_reg;
    logic [PAIR_W-1:0]      e_lo_reg;
    logic [H3_W-1:0]        e_h3_reg;
    logic [H3_W-1:0]        e_h3_next;
    logic                   f_valid_reg;
    tag_t                   f_tag_reg;
    tag_t                   f_tag_next;
    logic                   en_c;
    logic                   en_d;
    logic                   en_e;
    logic                   en_f;
    logic [RCP2_W-1:0]      rcp2;
    logic [Q_W+RCP2_W-1:0]  prod2;
    logic [7:0]             kval;
    logic [15:0]            hk;
    logic [7:0]             lo_raw;
    logic [HI_W+RCP3_W-1:0] prod3;
    logic [15:0]            h3k;
    logic [7:0]             hm_raw;
    logic [PAIR_W-1:0]      hm;

    assign en_f     = !f_valid_reg || out_ready;
    assign en_e     = !e_valid_reg || en_f;
    assign en_d     = !d_valid_reg || en_e;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    // Estimate quotient by 60 or 100
    always_comb
    begin
        case (in_data.tag.flags.ksel)
            KDIV_60: rcp2 = RCP_60;
            default: rcp2 = RCP_100;
        endcase
        prod2        = in_data.q * rcp2;
        c_hiest_next = prod2[HI_W+31:32];
    end

    // Correct the estimate and form the low part
    always_comb
    begin
        case (c_data_reg.tag.flags.ksel)
            KDIV_60: kval = 8'd60;
            default: kval = 8'd100;
        endcase
        hk     = c_hiest_reg[7:0] * kval;
        lo_raw = c_data_reg.q[7:0] - hk[7:0];
        if (lo_raw >= kval)
        begin
            d_hi_next = c_hiest_reg + 1'b1;
            d_lo_next = PAIR_W'(lo_raw - kval);
        end
        else
        begin
            d_hi_next = c_hiest_reg;
            d_lo_next = lo_raw[PAIR_W-1:0];
        end
    end

    // Estimate hundreds of the high part
    always_comb
    begin
        prod3     = d_hi_reg * RCP_H100;
        e_h3_next = prod3[H3_W+31:32];
    end

    // High part modulo 100, then pick arithmetic or direct pair values
    always_comb
    begin
        h3k    = e_h3_reg[7:0] * 8'd100;
        hm_raw = e_hi_reg[7:0] - h3k[7:0];
        hm     = (hm_raw >= 8'd100) ? PAIR_W'(hm_raw - 8'd100) : hm_raw[PAIR_W-1:0];
        f_tag_next = e_tag_reg;
        if (!e_tag_reg.flags.direct)
        begin
            f_tag_next.pair_hi = hm;
            f_tag_next.pair_lo = e_lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_c)
            begin
                c_valid_reg <= in_valid;
            end
            if (en_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (en_e)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (en_f)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_data_reg  <= in_data;
            c_hiest_reg <= c_hiest_next;
        end
        if (en_d)
        begin
            d_tag_reg <= c_data_reg.tag;
            d_hi_reg  <= d_hi_next;
            d_lo_reg  <= d_lo_next;
        end
        if (en_e)
        begin
            e_tag_reg <= d_tag_reg;
            e_hi_reg  <= d_hi_reg;
            e_lo_reg  <= d_lo_reg;
            e_h3_reg  <= e_h3_next;
        end
        if (en_f)
        begin
            f_tag_reg <= f_tag_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_tag_reg;

endmodule

/* design/tdf_digits.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_digits
// Output stage: turns the two pair values into four digits and holds the
// finished item until the sink takes it.
// ----------------------------------------------------------------------------
module tdf_digits (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tdf_pkg::tag_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tdf_pkg::result_t  out_data
);
    import tdf_pkg::*;

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    digits_t hi_d;
    digits_t lo_d;
    logic    en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Split pairs into digits
    always_comb
    begin
        hi_d                    = split_pair(in_data.pair_hi);
        lo_d                    = split_pair(in_data.pair_lo);
        data_next.digit_0       = hi_d.tens;
        data_next.digit_1       = hi_d.ones;
        data_next.digit_2       = lo_d.tens;
        data_next.digit_3       = lo_d.ones;
        data_next.blank_leading = in_data.flags.blank;
        data_next.colon_on      = in_data.flags.colon;
        data_next.decimal_on    = in_data.flags.dec;
        data_next.layout        = in_data.flags.layout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
